[design/sfdm_pkg.sv]
// ----------------------------------------------------------------------------
// sfdm_pkg
// Types and constants shared by the signed floor divide/modulo unit.
// ----------------------------------------------------------------------------
`default_nettype none

package sfdm_pkg;

	localparam int DATA_WIDTH = 32;

	// Command codes.
	localparam logic CMD_QUOT = 1'b0;
	localparam logic CMD_MOD  = 1'b1;

	// Status codes.
	localparam logic STATUS_OK       = 1'b0;
	localparam logic STATUS_DIV_ZERO = 1'b1;

	typedef struct packed {
		logic signed [DATA_WIDTH-1:0] dividend;
		logic signed [DATA_WIDTH-1:0] divisor;
		logic                         cmd;
	} in_t;

	typedef struct packed {
		logic signed [DATA_WIDTH-1:0] value;
		logic                         status;
	} out_t;

	// Working state carried down the divider pipeline.
	typedef struct packed {
		logic [DATA_WIDTH-1:0] rem;
		logic [DATA_WIDTH-1:0] quo;
		logic [DATA_WIDTH-1:0] mag_divisor;
		logic                  differ;
		logic                  neg_divisor;
		logic                  cmd;
		logic                  div_zero;
	} div_t;

endpackage

`default_nettype wire

[design/sfdm_div_step.sv]
// ----------------------------------------------------------------------------
// sfdm_div_step
// One registered step of the restoring divider: resolves one quotient bit.
// ----------------------------------------------------------------------------
`default_nettype none

module sfdm_div_step (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          up_valid,
	output logic               up_ready,
	input  wire sfdm_pkg::div_t up_data,
	output logic               dn_valid,
	input  wire logic          dn_ready,
	output sfdm_pkg::div_t     dn_data
);

	logic                            valid_q;
	sfdm_pkg::div_t                  data_q;
	sfdm_pkg::div_t                  next_data;
	logic [sfdm_pkg::DATA_WIDTH-1:0] shifted;
	logic [sfdm_pkg::DATA_WIDTH:0]   trial;
	logic                            fit;

	// For a nonzero divisor, the partial remainder stays below the divisor
	// magnitude, so the shifted value always fits in the data width.
	always_comb begin
		shifted   = {up_data.rem[sfdm_pkg::DATA_WIDTH-2:0],
			up_data.quo[sfdm_pkg::DATA_WIDTH-1]};
		trial     = {1'b0, shifted} - {1'b0, up_data.mag_divisor};
		fit       = ~trial[sfdm_pkg::DATA_WIDTH];
		next_data = up_data;
		next_data.rem = fit ? trial[sfdm_pkg::DATA_WIDTH-1:0] : shifted;
		next_data.quo = {up_data.quo[sfdm_pkg::DATA_WIDTH-2:0], fit};
	end

	assign up_ready = ~valid_q | dn_ready;
	assign dn_valid = valid_q;
	assign dn_data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			data_q <= next_data;
		end
	end

endmodule

`default_nettype wire

[design/signed_floor_divide_modulo_unit.sv]
// ----------------------------------------------------------------------------
// signed_floor_divide_modulo_unit
// Pipelined signed divider giving the floor quotient or floor remainder.
// ----------------------------------------------------------------------------
//
//  Channel   Signals                          Carries
//  --------  -------------------------------  --------------------------------
//  in        in_valid, in_ready, in_data      dividend, divisor, cmd
//  out       out_valid, out_ready, out_data   value, status
//
// One stage takes the magnitudes, one restoring step per quotient bit
// follows, then a floor correction stage and a sign and select stage. A new
// transaction can enter every cycle while the output is not stalled. Reset
// clears only the valid bits. Each stage holds its data while the stage
// after it is full and stalled, so bubbles are squeezed out and nothing is
// dropped or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module signed_floor_divide_modulo_unit (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire sfdm_pkg::in_t  in_data,
	output logic                out_valid,
	input  wire logic           out_ready,
	output sfdm_pkg::out_t      out_data
);

	localparam int W = sfdm_pkg::DATA_WIDTH;

	// Stage 1: operand magnitudes and sign flags.
	sfdm_pkg::div_t prep_next;
	sfdm_pkg::div_t prep_s1;
	logic           valid_s1;
	logic           ready_s1;
	logic           sx;
	logic           sy;
	logic [W-1:0]   x_raw;
	logic [W-1:0]   y_raw;

	always_comb begin
		x_raw = $unsigned(in_data.dividend);
		y_raw = $unsigned(in_data.divisor);
		sx    = x_raw[W-1];
		sy    = y_raw[W-1];
		prep_next.rem         = '0;
		prep_next.quo         = sx ? (W'(0) - x_raw) : x_raw;
		prep_next.mag_divisor = sy ? (W'(0) - y_raw) : y_raw;
		prep_next.differ      = sx ^ sy;
		prep_next.neg_divisor = sy;
		prep_next.cmd         = in_data.cmd;
		prep_next.div_zero    = (y_raw == '0);
	end

	// The divider chain: entry 0 is stage 1, entry k is the output of step k.
	logic           chain_valid [0:W];
	logic           chain_ready [0:W];
	sfdm_pkg::div_t chain_data  [0:W];

	assign ready_s1       = ~valid_s1 | chain_ready[0];
	assign in_ready       = ready_s1;
	assign chain_valid[0] = valid_s1;
	assign chain_data[0]  = prep_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && in_valid) begin
			prep_s1 <= prep_next;
		end
	end

	for (genvar k = 0; k < W; k++) begin : g_step
		sfdm_div_step u_step (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_valid (chain_valid[k]),
			.up_ready (chain_ready[k]),
			.up_data  (chain_data[k]),
			.dn_valid (chain_valid[k+1]),
			.dn_ready (chain_ready[k+1]),
			.dn_data  (chain_data[k+1])
		);
	end

	// Stage 2: floor correction. When the signs differ and the remainder is
	// nonzero, the truncated magnitude quotient is one short of the floor.
	sfdm_pkg::div_t fix_next;
	sfdm_pkg::div_t fix_s2;
	logic           valid_s2;
	logic           ready_s2;
	logic           ready_s3;

	always_comb begin
		fix_next = chain_data[W];
		if (chain_data[W].differ && (chain_data[W].rem != '0)) begin
			fix_next.quo = chain_data[W].quo + W'(1);
			fix_next.rem = chain_data[W].mag_divisor - chain_data[W].rem;
		end
	end

	assign ready_s2       = ~valid_s2 | ready_s3;
	assign chain_ready[W] = ready_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= chain_valid[W];
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && chain_valid[W]) begin
			fix_s2 <= fix_next;
		end
	end

	// Stage 3: apply signs, select the result and hold it for the consumer.
	sfdm_pkg::out_t result_next;
	sfdm_pkg::out_t result_s3;
	logic           valid_s3;
	logic [W-1:0]   quot;
	logic [W-1:0]   modv;

	always_comb begin
		quot = fix_s2.differ ? (W'(0) - fix_s2.quo) : fix_s2.quo;
		modv = fix_s2.neg_divisor ? (W'(0) - fix_s2.rem) : fix_s2.rem;
		if (fix_s2.div_zero) begin
			result_next.value  = '0;
			result_next.status = sfdm_pkg::STATUS_DIV_ZERO;
		end else begin
			result_next.value  = $signed((fix_s2.cmd == sfdm_pkg::CMD_MOD) ? modv : quot);
			result_next.status = sfdm_pkg::STATUS_OK;
		end
	end

	assign ready_s3  = ~valid_s3 | out_ready;
	assign out_valid = valid_s3;
	assign out_data  = result_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (ready_s3) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s3 && valid_s2) begin
			result_s3 <= result_next;
		end
	end

endmodule

`default_nettype wire

[sim/signed_floor_divide_modulo_unit_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// signed_floor_divide_modulo_unit_test
// Drives operand pairs into the floor divide/modulo unit with random gaps on
// both channels, predicts each result in a scoreboard and compares the results
// in order, field by field.
// ----------------------------------------------------------------------------

module signed_floor_divide_modulo_unit_test;

	localparam int DATA_WIDTH = sfdm_pkg::DATA_WIDTH;
	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = DATA_WIDTH + 10;
	localparam int RANDOM_ITEMS = 1626;
	localparam logic [DATA_WIDTH-1:0] MOST_NEG = {1'b1, {(DATA_WIDTH-1){1'b0}}};
	localparam logic [DATA_WIDTH-1:0] MOST_POS = {1'b0, {(DATA_WIDTH-1){1'b1}}};

	class divmod_scoreboard;
		sfdm_pkg::out_t pending_results[$];
		int unsigned mismatches;

		function new();
			mismatches = 0;
		endfunction

		task report(string what);
			$display("%0t: mismatch: %s", $time, what);
			mismatches++;
		endtask

		// Floor semantics: the quotient rounds toward minus infinity and a
		// nonzero remainder follows the sign of the divisor.
		function sfdm_pkg::out_t floor_divmod(sfdm_pkg::in_t op);
			logic [DATA_WIDTH-1:0] num, den, mag_num, mag_den, quo, rem;
			logic num_neg, den_neg, differ;
			sfdm_pkg::out_t res;
			res.status = sfdm_pkg::STATUS_OK;
			num = op.dividend;
			den = op.divisor;
			if (den == '0) begin
				res.value = '0;
				res.status = sfdm_pkg::STATUS_DIV_ZERO;
				return res;
			end
			if (den == 1) begin
				quo = num;
				rem = '0;
			end else if (den == '1) begin
				// Negation wraps, so the most negative dividend stays put.
				quo = -num;
				rem = '0;
			end else begin
				num_neg = num[DATA_WIDTH-1];
				den_neg = den[DATA_WIDTH-1];
				differ = num_neg ^ den_neg;
				mag_num = num_neg ? -num : num;
				mag_den = den_neg ? -den : den;
				quo = mag_num / mag_den;
				rem = mag_num % mag_den;
				if (differ && rem != '0) begin
					quo = quo + 1;
					rem = mag_den - rem;
				end
				if (differ)
					quo = -quo;
				if (den_neg)
					rem = -rem;
			end
			res.value = (op.cmd == sfdm_pkg::CMD_MOD) ? rem : quo;
			return res;
		endfunction

		function void note_input(sfdm_pkg::in_t op);
			pending_results.push_back(floor_divmod(op));
		endfunction

		task check_result(sfdm_pkg::out_t got);
			sfdm_pkg::out_t want;
			if (pending_results.size() == 0) begin
				report($sformatf("result value=%h status=%b with nothing pending",
					got.value, got.status));
				return;
			end
			want = pending_results.pop_front();
			if (got.value !== want.value)
				report($sformatf("value %h, predicted %h", got.value, want.value));
			if (got.status !== want.status)
				report($sformatf("status %b, predicted %b", got.status, want.status));
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	sfdm_pkg::in_t in_data;
	logic out_valid;
	logic out_ready;
	sfdm_pkg::out_t out_data;

	divmod_scoreboard board;
	bit idle_on;
	int unsigned cycles;
	logic [DATA_WIDTH-1:0] corner_num[12];
	logic [DATA_WIDTH-1:0] corner_den[12];

	signed_floor_divide_modulo_unit u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	initial begin
		clk = 1'b0;
	end

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL signed_floor_divide_modulo_unit");
			$finish;
		end
	end

	// The receiver stalls at random, with a probability of about 7 percent, while idling is enabled.
	always @(negedge clk) begin
		if (arst_n)
			out_ready <= !(idle_on && $urandom_range(99) < 7);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			board.check_result(out_data);
	end

	// The sender leaves a single idle cycle before about 7 transactions of 100.
	task automatic send_item(input sfdm_pkg::in_t item);
		if (idle_on && $urandom_range(99) < 7) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid <= 1'b1;
		in_data <= item;
		do @(posedge clk); while (!in_ready);
		board.note_input(item);
	endtask

	task automatic send_op(input logic [DATA_WIDTH-1:0] num,
		input logic [DATA_WIDTH-1:0] den, input logic op_cmd);
		sfdm_pkg::in_t item;
		item.dividend = num;
		item.divisor = den;
		item.cmd = op_cmd;
		send_item(item);
	endtask

	// Operands are drawn from a mix of full-range, small, power-of-two and
	// extreme values so that every rounding and sign case shows up often.
	function automatic logic [DATA_WIDTH-1:0] pick_operand();
		logic [DATA_WIDTH-1:0] pick;
		case ($urandom_range(5))
			0, 1: pick = $urandom();
			2: pick = $urandom_range(40) - 20;
			3: pick = {{(DATA_WIDTH-1){1'b0}}, 1'b1} << $urandom_range(DATA_WIDTH - 1);
			4: pick = -({{(DATA_WIDTH-1){1'b0}}, 1'b1} << $urandom_range(DATA_WIDTH - 1));
			default: begin
				case ($urandom_range(4))
					0: pick = MOST_NEG;
					1: pick = MOST_POS;
					2: pick = '0;
					3: pick = '1;
					default: pick = 1;
				endcase
			end
		endcase
		return pick;
	endfunction

	task automatic wait_for_results();
		while (board.pending_results.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		sfdm_pkg::in_t item;
		board = new();
		cycles = 0;
		idle_on = 1'b1;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_ready = 1'b0;
		corner_num = '{MOST_NEG, MOST_POS, MOST_NEG, -9, 7, -7, 7, -7,
			MOST_NEG, MOST_POS, '1, 0};
		corner_den = '{'1, '1, 1, 0, 2, 2, -2, -2,
			MOST_POS, MOST_NEG, MOST_NEG, -5};
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;

		// Corner cases: the wrapping quotient, both unit divisors, division by
		// zero, every sign combination with a nonzero remainder, and extremes.
		for (int i = 0; i < 12; i++) begin
			send_op(corner_num[i], corner_den[i], sfdm_pkg::CMD_QUOT);
			send_op(corner_num[i], corner_den[i], sfdm_pkg::CMD_MOD);
		end

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == 600)
				idle_on = 1'b0;
			if (n == 900)
				idle_on = 1'b1;
			if (n == 1200) begin
				// Let the pipeline empty completely before going on.
				@(negedge clk);
				in_valid <= 1'b0;
				wait_for_results();
			end
			item.dividend = pick_operand();
			item.divisor = pick_operand();
			item.cmd = $urandom_range(1) ? sfdm_pkg::CMD_MOD : sfdm_pkg::CMD_QUOT;
			send_item(item);
		end

		@(negedge clk);
		in_valid <= 1'b0;
		wait_for_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.mismatches == 0)
			$display("PASS signed_floor_divide_modulo_unit");
		else
			$display("FAIL signed_floor_divide_modulo_unit");
		$finish;
	end

endmodule

[files.f]
design/sfdm_pkg.sv
design/sfdm_div_step.sv
design/signed_floor_divide_modulo_unit.sv
sim/signed_floor_divide_modulo_unit_test.sv
